// ===== src/esd_pkg.sv =====
package esd_pkg;

  // field widths
  localparam int unsigned IN_W   = 40;
  localparam int unsigned LATENCY = 9;

  // seconds to days: t / 86400 = (t >> 7) / 675
  localparam logic [9:0]  DAY_UNITS  = 10'd675;
  localparam logic [31:0] DAY_RECIP  = 32'((64'd1 << 41) / 64'd675);

  // saturation point and march-based origin shift
  localparam logic [21:0] LAST_DAY    = 22'd2932896;
  localparam logic [16:0] LAST_SEC    = 17'd86399;
  localparam logic [21:0] MARCH_SHIFT = 22'd719468;

  // year estimate: (d + 2) * 400 / 146097
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [31:0] YEAR_RECIP   = 32'((64'd1 << 48) / 64'd146097);

  // exact reciprocals for narrow operands
  localparam logic [16:0] HOUR_RECIP = 17'd74566;  // / 3600, shift 28
  localparam logic [12:0] MIN_RECIP  = 13'd4370;   // / 60, shift 18
  localparam logic [13:0] C100_RECIP = 14'd10486;  // / 100, shift 20
  localparam logic [10:0] MON_RECIP  = 11'd1714;   // / 153, shift 18

  localparam logic [8:0]  LATE_YDAY  = 9'd306;

  // day count and time of day handed from the splitter to the back end
  typedef struct packed {
    logic [21:0] mday;   // days from the march-based origin of year 0
    logic [30:0] span;   // (mday + 2) * 400
    logic [16:0] sod;    // second of the day
    logic [2:0]  wday;   // 0 = sunday
  } esd_day_t;

  // floor(367 * m / 12), first day of each march-based month
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/esd_split.sv =====
module esd_split (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [39:0]       in_epoch,
  output logic                     out_vld,
  output esd_pkg::esd_day_t        out_day
);
  import esd_pkg::*;

  logic [2:0]  vld_r;
  logic [22:0] q0_r, q0_nxt;
  logic [31:0] x_r, x_nxt;
  logic [6:0]  lo_r, lo_nxt;
  logic [22:0] days_r, days_nxt;
  logic [16:0] sod_r, sod_nxt;
  esd_day_t    day_r, day_nxt;

  // stage 0: clamp negatives, reciprocal multiply for the day estimate
  logic [38:0] t;
  logic [63:0] dprod;
  always_comb begin
    t      = in_epoch[IN_W-1] ? '0 : in_epoch[IN_W-2:0];
    x_nxt  = t[38:7];
    lo_nxt = t[6:0];
    dprod  = 64'(x_nxt) * 64'(DAY_RECIP);
    q0_nxt = dprod[63:41];
  end

  // stage 1: remainder and one-step correction
  logic [32:0] qm;
  logic [31:0] rfull;
  logic [10:0] r11;
  logic        fix;
  always_comb begin
    qm       = 33'(q0_r) * 33'(DAY_UNITS);
    rfull    = x_r - qm[31:0];
    r11      = rfull[10:0];
    fix      = r11 >= 11'(DAY_UNITS);
    days_nxt = fix ? q0_r + 23'd1 : q0_r;
    sod_nxt  = {(fix ? 10'(r11 - 11'(DAY_UNITS)) : r11[9:0]), lo_r};
  end

  // stage 2: saturate past year 9999, march-based day count, weekday
  logic        over;
  logic [21:0] dc, md;
  logic [23:0] w;
  logic [5:0]  s1;
  logic [3:0]  s2;
  logic [2:0]  s3;
  always_comb begin
    over = days_r > {1'b0, LAST_DAY};
    dc   = over ? LAST_DAY : days_r[21:0];
    md   = dc + MARCH_SHIFT;
    day_nxt.mday = md;
    day_nxt.span = 31'({9'd0, md} + 31'd2) * 31'd400;
    day_nxt.sod  = over ? LAST_SEC : sod_r;
    // (dc + 4) mod 7 by folding octal digits, since 8 is 1 mod 7
    w  = 24'(dc) + 24'd4;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    day_nxt.wday = (s3 == 3'd7) ? 3'd0 : s3;
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // payload pipe
  always_ff @(posedge clk) begin
    q0_r   <= q0_nxt;
    x_r    <= x_nxt;
    lo_r   <= lo_nxt;
    days_r <= days_nxt;
    sod_r  <= sod_nxt;
    day_r  <= day_nxt;
  end

  assign out_vld = vld_r[2];
  assign out_day = day_r;

endmodule

// ===== src/esd_tod.sv =====
module esd_tod (
  input  logic        clk,
  input  logic [16:0] in_sod,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);
  import esd_pkg::*;

  logic [16:0] s1_r;
  logic [4:0]  h1_r, h2_r, h3_r, h4_r, h5_r, h6_r, h1_nxt;
  logic [11:0] r2_r, r3_r, r2_nxt;
  logic [5:0]  m3_r, m4_r, m5_r, m6_r, m3_nxt;
  logic [5:0]  c4_r, c5_r, c6_r, c4_nxt;

  // hour by exact reciprocal
  logic [33:0] hp;
  always_comb begin
    hp     = 34'(in_sod) * 34'(HOUR_RECIP);
    h1_nxt = hp[32:28];
  end

  // seconds within the hour
  logic [16:0] hm;
  always_comb begin
    hm     = 17'(h1_r) * 17'd3600;
    r2_nxt = 12'(s1_r - hm);
  end

  // minute by exact reciprocal
  logic [23:0] mp;
  always_comb begin
    mp     = 24'(r2_r) * 24'(MIN_RECIP);
    m3_nxt = mp[23:18];
  end

  // second within the minute
  always_comb begin
    c4_nxt = 6'(r3_r - 12'(m3_r) * 12'd60);
  end

  // stages, the last two only align with the calendar path
  always_ff @(posedge clk) begin
    s1_r <= in_sod;
    h1_r <= h1_nxt;
    h2_r <= h1_r;
    r2_r <= r2_nxt;
    h3_r <= h2_r;
    r3_r <= r2_r;
    m3_r <= m3_nxt;
    h4_r <= h3_r;
    m4_r <= m3_r;
    c4_r <= c4_nxt;
    h5_r <= h4_r;
    m5_r <= m4_r;
    c5_r <= c4_r;
    h6_r <= h5_r;
    m6_r <= m5_r;
    c6_r <= c5_r;
  end

  assign out_hour   = h6_r;
  assign out_minute = m6_r;
  assign out_second = c6_r;

endmodule

// ===== src/esd_cal.sv =====
module esd_cal (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  esd_pkg::esd_day_t   in_day,
  output logic                out_vld,
  output logic [4:0]          out_day_of_month,
  output logic [3:0]          out_month,
  output logic [13:0]         out_year,
  output logic [2:0]          out_weekday
);
  import esd_pkg::*;

  logic [5:0]  vld_r;
  logic [2:0]  wd_r [6];
  logic [13:0] y0_r, y0_nxt, y2_r, y2_nxt, y3_r, y4_r, y4_nxt, y5_r;
  logic [30:0] span1_r;
  logic [21:0] md1_r, md2_r, md3_r;
  logic [6:0]  c3_r, c3_nxt;
  logic [21:0] y365_r, y365_nxt;
  logic [8:0]  yd4_r, yd4_nxt, yd5_r;
  logic [3:0]  mon5_r, mon5_nxt;
  logic [4:0]  dom_r, dom_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [13:0] year_r, year_nxt;

  // year estimate by reciprocal multiply
  logic [62:0] yp;
  always_comb begin
    yp     = 63'(in_day.span) * 63'(YEAR_RECIP);
    y0_nxt = yp[61:48];
  end

  // one-step correction of the estimate
  logic [30:0] ym, chk;
  always_comb begin
    ym     = 31'(y0_r) * 31'(DAYS_PER_ERA);
    chk    = span1_r - ym;
    y2_nxt = (chk >= 31'(DAYS_PER_ERA)) ? y0_r + 14'd1 : y0_r;
  end

  // centuries and whole-year days
  logic [26:0] cp;
  always_comb begin
    cp        = 27'(y2_r) * 27'(C100_RECIP);
    c3_nxt    = cp[26:20];
    y365_nxt  = 22'(y2_r) * 22'd365;
  end

  // day of the march-based year, borrowing a year when it comes out negative
  logic [21:0] ydays;
  logic [22:0] diff;
  logic [6:0]  r100;
  logic        leap;
  always_comb begin
    ydays   = y365_r + 22'(y3_r[13:2]) - 22'(c3_r) + 22'(c3_r[6:2]);
    diff    = {1'b0, md3_r} - {1'b0, ydays};
    r100    = 7'(y3_r - 14'(c3_r) * 14'd100);
    leap    = (y3_r[1:0] == 2'b00) && ((r100 != 7'd0) || (c3_r[1:0] == 2'b00));
    yd4_nxt = diff[22] ? 9'(diff + 23'd365 + 23'(leap)) : diff[8:0];
    y4_nxt  = diff[22] ? y3_r - 14'd1 : y3_r;
  end

  // march-based month
  logic [10:0] mx;
  logic [21:0] mp;
  always_comb begin
    mx       = 11'({2'b0, yd4_r} + 11'd31) * 11'd5;
    mp       = 22'(mx) * 22'(MON_RECIP);
    mon5_nxt = mp[21:18];
  end

  // day of month and shift back to a january-based year
  logic [9:0] dm;
  logic       late;
  always_comb begin
    dm       = 10'({1'b0, yd5_r}) + 10'd31 - 10'(month_start(mon5_r));
    dom_nxt  = dm[4:0];
    late     = yd5_r >= LATE_YDAY;
    mon_nxt  = late ? mon5_r - 4'd10 : mon5_r + 4'd2;
    year_nxt = late ? y5_r + 14'd1 : y5_r;
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  // payload pipe
  always_ff @(posedge clk) begin
    wd_r[0] <= in_day.wday;
    for (int i = 1; i < 6; i++) begin
      wd_r[i] <= wd_r[i-1];
    end
    y0_r    <= y0_nxt;
    span1_r <= in_day.span;
    md1_r   <= in_day.mday;
    y2_r    <= y2_nxt;
    md2_r   <= md1_r;
    y3_r    <= y2_r;
    c3_r    <= c3_nxt;
    y365_r  <= y365_nxt;
    md3_r   <= md2_r;
    yd4_r   <= yd4_nxt;
    y4_r    <= y4_nxt;
    yd5_r   <= yd4_r;
    y5_r    <= y4_r;
    mon5_r  <= mon5_nxt;
    dom_r   <= dom_nxt;
    mon_r   <= mon_nxt;
    year_r  <= year_nxt;
  end

  assign out_vld          = vld_r[5];
  assign out_day_of_month = dom_r;
  assign out_month        = mon_r;
  assign out_year         = year_r;
  assign out_weekday      = wd_r[5];

endmodule

// ===== src/epoch_seconds_to_utc_date.sv =====
// channel      | ports                                        | handshake
// -------------+----------------------------------------------+---------------------------
// input        | in_epoch_seconds                             | start high, busy low
// result       | out_second, out_minute, out_hour,            | out_valid for one cycle
//              | out_day_of_month, out_month, out_year,       |
//              | out_weekday                                  |
//
// one transaction per cycle; each result follows its start through the nine register
// stages of the day split and calendar path.
// busy is never raised and the receiver cannot stall, so the pipe always moves.
// synchronous reset clears the valid bits only; transactions in flight are dropped.
module epoch_seconds_to_utc_date (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [39:0] in_epoch_seconds,
  output logic               out_valid,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month,
  output logic [13:0]        out_year,
  output logic [2:0]         out_weekday
);
  import esd_pkg::*;

  logic     day_vld;
  esd_day_t day;

  // never holds off a transaction
  assign busy = 1'b0;

  // seconds to day count and second of day
  esd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_epoch (in_epoch_seconds),
    .out_vld  (day_vld),
    .out_day  (day)
  );

  // time of day
  esd_tod u_tod (
    .clk        (clk),
    .in_sod     (day.sod),
    .out_hour   (out_hour),
    .out_minute (out_minute),
    .out_second (out_second)
  );

  // calendar date
  esd_cal u_cal (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (day_vld),
    .in_day           (day),
    .out_vld          (out_valid),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

endmodule

// ===== src/esd_checker.sv =====
module esd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [39:0] in_epoch_seconds,
  input logic               out_valid,
  input logic [5:0]         out_second,
  input logic [5:0]         out_minute,
  input logic [4:0]         out_hour,
  input logic [4:0]         out_day_of_month,
  input logic [3:0]         out_month,
  input logic [13:0]        out_year,
  input logic [2:0]         out_weekday
);
  import esd_pkg::*;

  // the pipe never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted transaction yields a result after the fixed latency
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("spurious result");

  // fields within their calendar ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second <= 6'd59 && out_minute <= 6'd59 && out_hour <= 5'd23 &&
                   out_day_of_month >= 5'd1 && out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_year >= 14'd1970 && out_year <= 14'd9999 && out_weekday <= 3'd6))
    else $error("field out of range");

  // negative input saturates to the epoch, a thursday
  a_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_epoch_seconds[39]) |-> ##LATENCY
      (out_year == 14'd1970 && out_month == 4'd1 && out_day_of_month == 5'd1 &&
       out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0 &&
       out_weekday == 3'd4))
    else $error("negative input not saturated");

endmodule

bind epoch_seconds_to_utc_date esd_checker u_esd_checker (.*);

// ===== test/tb_epoch_seconds_to_utc_date.sv =====
module tb_epoch_seconds_to_utc_date;
  import esd_pkg::*;

  // last representable moment, 9999-12-31 23:59:59
  localparam logic [39:0] LAST_MOMENT = 40'd253402300799;
  localparam int unsigned DIRECTED_N = 25;
  localparam int unsigned RANDOM_N   = 800;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } utc_date_t;

  // calendar prediction and in-order comparison of converted dates
  class date_tracker;
    utc_date_t due_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endfunction

    // gregorian breakdown via a march-based year
    function utc_date_t civil_date_of(logic [39:0] raw);
      utc_date_t d;
      longint total, days, sod, y, m, yday, md;
      bit leap;
      total = raw[39] ? 64'd0 : {24'd0, raw};
      days = total / 86400;
      sod = total % 86400;
      // clamp past the last day of year 9999
      if (days > 2932896) begin
        days = 2932896;
        sod = 86399;
      end
      d.weekday = 3'((4 + days) % 7);
      d.hour = 5'(sod / 3600);
      d.minute = 6'((sod % 3600) / 60);
      d.second = 6'(sod % 60);
      // shift origin to 0000-03-01
      days = days + 719468;
      y = (days + 2) * 400 / 146097;
      yday = days - (365 * y + y / 4 - y / 100 + y / 400);
      // estimate overshot by one year
      if (yday < 0) begin
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        yday = 365 + (leap ? 1 : 0) + yday;
        y--;
      end
      m = (yday + 31) * 10 / 306;
      md = yday - (367 * m / 12 - 30) + 1;
      // january and february belong to the following civil year
      if (yday >= 306) begin
        y++;
        m -= 10;
      end else begin
        m += 2;
      end
      d.mday = 5'(md);
      d.month = 4'(m);
      d.year = 14'(y);
      return d;
    endfunction

    function void note_seconds(logic [39:0] raw);
      due_dates.push_back(civil_date_of(raw));
    endfunction

    function void check_date(utc_date_t got);
      utc_date_t want;
      if (due_dates.size() == 0) begin
        report("result with nothing outstanding", 0, 0);
        return;
      end
      want = due_dates.pop_front();
      if (got.second !== want.second) report("second", got.second, want.second);
      if (got.minute !== want.minute) report("minute", got.minute, want.minute);
      if (got.hour !== want.hour) report("hour", got.hour, want.hour);
      if (got.mday !== want.mday) report("day_of_month", got.mday, want.mday);
      if (got.month !== want.month) report("month", got.month, want.month);
      if (got.year !== want.year) report("year", got.year, want.year);
      if (got.weekday !== want.weekday) report("weekday", got.weekday, want.weekday);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [39:0] in_epoch_seconds = '0;
  logic busy;
  logic out_valid;
  logic [5:0] out_second;
  logic [5:0] out_minute;
  logic [4:0] out_hour;
  logic [4:0] out_day_of_month;
  logic [3:0] out_month;
  logic [13:0] out_year;
  logic [2:0] out_weekday;

  date_tracker dates = new();
  int unsigned calm_left = 0;
  bit calm = 1'b0;

  epoch_seconds_to_utc_date DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) dates.note_seconds(in_epoch_seconds);
      if (out_valid) begin
        dates.check_date({out_second, out_minute, out_hour, out_day_of_month,
                          out_month, out_year, out_weekday});
      end
    end
  end

  // sender gap: bursts with no idling alternate with random gaps
  function automatic int unsigned next_gap();
    if (calm_left == 0) begin
      calm_left = $urandom_range(1, 30);
      calm = ($urandom_range(0, 2) == 0);
    end
    calm_left--;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // one transaction: idle for the gap, then hold start until accepted
  task automatic send_seconds(input logic [39:0] secs);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random timestamp, weighted towards the valid calendar range
  function automatic logic [39:0] random_seconds();
    logic [63:0] w;
    longint unsigned day;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return w[39:0];
      2: return {1'b1, w[38:0]};
      3: begin
        // either side of a midnight
        day = $urandom_range(1, 2932897);
        return 40'(day * 86400 - 64'($urandom_range(0, 1)));
      end
      4: return 40'(longint'(LAST_MOMENT) + longint'($urandom_range(0, 400000)) - 200000);
      5: return 40'(w[31:0]);
      default: return 40'(w % (64'(LAST_MOMENT) + 1));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [39:0] directed [DIRECTED_N];
    directed = '{
      40'd0, 40'd1, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
      40'd5097599, 40'd5097600,                     // end of february 1970
      40'd946684799, 40'd946684800,                 // turn of 2000
      40'd951782400, 40'd951868800,                 // leap day 2000, then march
      40'd4107456000, 40'd4107542400,               // no leap day in 2100
      40'd2147483647, 40'd2147483648, 40'd4294967296,
      LAST_MOMENT - 40'd1, LAST_MOMENT, LAST_MOMENT + 40'd1,
      40'h7f_ffff_ffff,                             // largest positive
      40'hff_ffff_ffff,                             // minus one
      40'h80_0000_0000                              // most negative
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_seconds(directed[i]);
    repeat (RANDOM_N) send_seconds(random_seconds());
    start <= 1'b0;
    // drain the pipe
    while (dates.due_dates.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (dates.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/esd_pkg.sv
src/esd_split.sv
src/esd_tod.sv
src/esd_cal.sv
src/epoch_seconds_to_utc_date.sv
src/esd_checker.sv
test/tb_epoch_seconds_to_utc_date.sv
